/* rtl/pstd_pkg.sv */
// ----------------------------------------------------------------------------
// pstd_pkg
// Shared constants, codes and controller/datapath interface types for the
// point store with toroidal distance.
// ----------------------------------------------------------------------------
`default_nettype none

package pstd_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;

   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int WIDTH_W    = COORD_BITS + 1;
   localparam int SQ_W       = 2 * COORD_BITS;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int ITER_W     = $clog2(ROOT_W);
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = WIDTH_W;

   // window extent after reset: the full coordinate range
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = {1'b1, {COORD_BITS{1'b0}}};

   typedef enum logic [REQ_W-1:0] {
      OP_APPEND,
      OP_DROP,
      OP_MOVE,
      OP_ERASE,
      OP_DIST,
      OP_READ
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BAD_INDEX,
      ST_FULL
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THREE_D,
      CSR_WRAP,
      CSR_WIDTH_X,
      CSR_WIDTH_Y,
      CSR_WIDTH_Z
   } csr_type;

   typedef enum logic [1:0] {
      RD_A,
      RD_B,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_APPEND,
      WR_MOVE,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      AX_X,
      AX_Y,
      AX_Z
   } axis_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_CLEAR,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ERASE_RD,
      S_ERASE_WR,
      S_DIST_B,
      S_DIST_DIFF,
      S_DIST_WRAP,
      S_SQR_X,
      S_SQR_Y,
      S_SQR_Z,
      S_SUM,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_READ_TAKE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       status_we;
      status_type status_code;
      logic       cnt_inc;
      logic       cnt_dec;
      rd_sel_type rd_sel;
      logic       mem_we;
      wr_sel_type wr_sel;
      logic       ptr_load;
      logic       ptr_inc;
      logic       cap_a;
      logic       cap_diff;
      logic       cap_wrap;
      axis_type   sq_sel;
      acc_op_type acc_op;
      logic       sqrt_start;
      logic       take_root;
      logic       take_read;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] op;
      logic             full;
      logic             empty;
      logic             a_ok;
      logic             b_ok;
      logic             same;
      logic             shift_last;
      logic             sqrt_done;
   } sts_type;

endpackage

`default_nettype wire

/* rtl/point_store_toroidal_distance.sv */
// ----------------------------------------------------------------------------
// point_store_toroidal_distance
// An erase moves n = count-1-index_a entries down; a distance ends with the
// square root iterations.
// One item at a time: the next is taken in the cycle after the result is loaded.
// Reset (synchronous): table empty, 2D, no wrap, all window extents 65536.
// ----------------------------------------------------------------------------
`default_nettype none

// Table of 2D/3D points with append, drop, move, erase, read and distance.
//
// Structure:
//   pstd_ctrl   - sequencer, one state per step of an item
//   pstd_dpath  - three point memories (one write and one registered read
//                 port each), count, control registers, distance pipeline,
//                 result and output registers
//   pstd_isqrt  - radix-4 floor square root, one bit of root per cycle
//
// Rate is set by the single memory read port (erase: one read and one write
//   per moved entry) and by the square root iterations.
// Distance path: |a-b| per axis, toroidal fold, one shared 16x16 squarer
//   used for each axis in turn, 34-bit sum, then the square root.
// The output register holds a finished item while rsp_stall is high; the
//   next item is already accepted and worked on meanwhile, and only waits
//   at its own hand-over.
// Control register writes are always taken (csr_ready tied high); the user
//   must make them only while the block is idle; the block has no check for this.

module point_store_toroidal_distance (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [pstd_pkg::REQ_W-1:0]          req_type,
   input  wire logic [pstd_pkg::IDX_W-1:0]          req_index_a,
   input  wire logic [pstd_pkg::IDX_W-1:0]          req_index_b,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_x,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_y,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_z,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [pstd_pkg::CNT_W-1:0]               rsp_point_count,
   output logic [pstd_pkg::ROOT_W-1:0]              rsp_distance,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_x,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_y,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_z,
   output logic [pstd_pkg::STATUS_W-1:0]            rsp_status,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pstd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pstd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   pstd_pkg::cmd_type cmd;
   pstd_pkg::sts_type sts;
   logic              csr_we;

   // registers are plain flops, writable every cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   pstd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pstd_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_type        (req_type),
      .req_index_a     (req_index_a),
      .req_index_b     (req_index_b),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_point_count (rsp_point_count),
      .rsp_distance    (rsp_distance),
      .rsp_read_x      (rsp_read_x),
      .rsp_read_y      (rsp_read_y),
      .rsp_read_z      (rsp_read_z),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

/* rtl/pstd_isqrt.sv */
// ----------------------------------------------------------------------------
// pstd_isqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pstd_isqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [pstd_pkg::SUM_W-1:0]      radicand,
   output logic                                 done,
   output logic [pstd_pkg::ROOT_W-1:0]          root
);

   logic                            run_ff;
   logic                            run_in;
   logic                            done_ff;
   logic                            done_in;
   logic [pstd_pkg::SUM_W-1:0]      v_ff;
   logic [pstd_pkg::SUM_W-1:0]      v_in;
   logic [pstd_pkg::REM_W-1:0]      rem_ff;
   logic [pstd_pkg::REM_W-1:0]      rem_in;
   logic [pstd_pkg::ROOT_W-1:0]     root_ff;
   logic [pstd_pkg::ROOT_W-1:0]     root_in;
   logic [pstd_pkg::ITER_W-1:0]     cnt_ff;
   logic [pstd_pkg::ITER_W-1:0]     cnt_in;
   logic [pstd_pkg::REM_W-1:0]      rem_sh;
   logic [pstd_pkg::REM_W-1:0]      trial;

   // bring down the next bit pair, try root*4+1
   assign rem_sh = {rem_ff[pstd_pkg::REM_W-3:0], v_ff[pstd_pkg::SUM_W-1 -: 2]};
   assign trial  = pstd_pkg::REM_W'({root_ff, 2'b01});

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         run_in  = 1'b1;
         v_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = pstd_pkg::ITER_W'(pstd_pkg::ROOT_W - 1);
      end else if (run_ff) begin
         v_in = {v_ff[pstd_pkg::SUM_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[pstd_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[pstd_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - pstd_pkg::ITER_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

/* rtl/pstd_ctrl.sv */
// ----------------------------------------------------------------------------
// pstd_ctrl
// Request sequencer: decodes each item, steps the datapath and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pstd_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire pstd_pkg::sts_type sts,
   output pstd_pkg::cmd_type      cmd
);

   pstd_pkg::state_type state_ff;
   pstd_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         pstd_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = pstd_pkg::S_DECODE;
            end
         end
         pstd_pkg::S_DECODE: begin
            state_in        = pstd_pkg::S_FINISH;
            cmd.status_we   = 1'b1;
            cmd.status_code = pstd_pkg::ST_OK;
            unique case (sts.op)
               pstd_pkg::OP_APPEND: begin
                  if (sts.full) begin
                     cmd.status_code = pstd_pkg::ST_FULL;
                  end else begin
                     cmd.mem_we  = 1'b1;
                     cmd.wr_sel  = pstd_pkg::WR_APPEND;
                     cmd.cnt_inc = 1'b1;
                  end
               end
               pstd_pkg::OP_DROP: begin
                  if (sts.empty) begin
                     cmd.status_code = pstd_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.cnt_dec = 1'b1;
                  end
               end
               pstd_pkg::OP_MOVE: begin
                  if (!sts.a_ok) begin
                     cmd.status_code = pstd_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.mem_we = 1'b1;
                     cmd.wr_sel = pstd_pkg::WR_MOVE;
                  end
               end
               pstd_pkg::OP_ERASE: begin
                  if (!sts.a_ok) begin
                     cmd.status_code = pstd_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.ptr_load = 1'b1;
                     state_in     = pstd_pkg::S_ERASE_RD;
                  end
               end
               pstd_pkg::OP_DIST: begin
                  if (!sts.a_ok || !sts.b_ok) begin
                     cmd.status_code = pstd_pkg::ST_BAD_INDEX;
                  end else if (!sts.same) begin
                     cmd.rd_sel = pstd_pkg::RD_A;
                     state_in   = pstd_pkg::S_DIST_B;
                  end
               end
               pstd_pkg::OP_READ: begin
                  if (!sts.a_ok) begin
                     cmd.status_code = pstd_pkg::ST_BAD_INDEX;
                  end else begin
                     cmd.rd_sel = pstd_pkg::RD_A;
                     state_in   = pstd_pkg::S_READ_TAKE;
                  end
               end
               default: begin
               end
            endcase
         end
         pstd_pkg::S_ERASE_RD: begin
            if (sts.shift_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = pstd_pkg::S_FINISH;
            end else begin
               cmd.rd_sel = pstd_pkg::RD_NEXT;
               state_in   = pstd_pkg::S_ERASE_WR;
            end
         end
         pstd_pkg::S_ERASE_WR: begin
            cmd.mem_we  = 1'b1;
            cmd.wr_sel  = pstd_pkg::WR_SHIFT;
            cmd.ptr_inc = 1'b1;
            state_in    = pstd_pkg::S_ERASE_RD;
         end
         pstd_pkg::S_DIST_B: begin
            cmd.cap_a  = 1'b1;
            cmd.rd_sel = pstd_pkg::RD_B;
            state_in   = pstd_pkg::S_DIST_DIFF;
         end
         pstd_pkg::S_DIST_DIFF: begin
            cmd.cap_diff = 1'b1;
            state_in     = pstd_pkg::S_DIST_WRAP;
         end
         pstd_pkg::S_DIST_WRAP: begin
            cmd.cap_wrap = 1'b1;
            state_in     = pstd_pkg::S_SQR_X;
         end
         pstd_pkg::S_SQR_X: begin
            cmd.sq_sel = pstd_pkg::AX_X;
            cmd.acc_op = pstd_pkg::ACC_CLEAR;
            state_in   = pstd_pkg::S_SQR_Y;
         end
         pstd_pkg::S_SQR_Y: begin
            cmd.sq_sel = pstd_pkg::AX_Y;
            cmd.acc_op = pstd_pkg::ACC_ADD;
            state_in   = pstd_pkg::S_SQR_Z;
         end
         pstd_pkg::S_SQR_Z: begin
            cmd.sq_sel = pstd_pkg::AX_Z;
            cmd.acc_op = pstd_pkg::ACC_ADD;
            state_in   = pstd_pkg::S_SUM;
         end
         pstd_pkg::S_SUM: begin
            cmd.acc_op = pstd_pkg::ACC_ADD;
            state_in   = pstd_pkg::S_SQRT_GO;
         end
         pstd_pkg::S_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = pstd_pkg::S_SQRT_WAIT;
         end
         pstd_pkg::S_SQRT_WAIT: begin
            if (sts.sqrt_done) begin
               cmd.take_root = 1'b1;
               state_in      = pstd_pkg::S_FINISH;
            end
         end
         pstd_pkg::S_READ_TAKE: begin
            cmd.take_read = 1'b1;
            state_in      = pstd_pkg::S_FINISH;
         end
         pstd_pkg::S_FINISH: begin
            if (slot_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pstd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pstd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pstd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != pstd_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pstd_pkg::S_FINISH && !slot_free) |=> state_ff == pstd_pkg::S_FINISH)
      else $error("result dropped while output register occupied");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("second item taken while one is in work");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

`default_nettype wire

/* rtl/pstd_dpath.sv */
// ----------------------------------------------------------------------------
// pstd_dpath
// Point memories, count, control registers, distance arithmetic and the
// result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pstd_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pstd_pkg::cmd_type                   cmd,
   output pstd_pkg::sts_type                        sts,
   input  wire logic [pstd_pkg::REQ_W-1:0]          req_type,
   input  wire logic [pstd_pkg::IDX_W-1:0]          req_index_a,
   input  wire logic [pstd_pkg::IDX_W-1:0]          req_index_b,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_x,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_y,
   input  wire logic [pstd_pkg::COORD_BITS-1:0]     req_coord_z,
   input  wire logic                                csr_we,
   input  wire logic [pstd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pstd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [pstd_pkg::CNT_W-1:0]               rsp_point_count,
   output logic [pstd_pkg::ROOT_W-1:0]              rsp_distance,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_x,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_y,
   output logic [pstd_pkg::COORD_BITS-1:0]          rsp_read_z,
   output logic [pstd_pkg::STATUS_W-1:0]            rsp_status
);

   localparam int CW = pstd_pkg::COORD_BITS;
   localparam int IW = pstd_pkg::IDX_W;
   localparam int NW = pstd_pkg::CNT_W;
   localparam int WW = pstd_pkg::WIDTH_W;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] p,
                                              input logic [CW-1:0] q);
      return (p > q) ? (p - q) : (q - p);
   endfunction

   // toroidal fold of one axis difference; a window narrower than the
   // difference gives d - w
   function automatic logic [CW-1:0] fold(input logic [CW-1:0] d,
                                          input logic [WW-1:0] w,
                                          input logic          en);
      logic [WW-1:0] d_ext;
      logic [WW-1:0] other;
      logic [CW-1:0] r;
      d_ext = {1'b0, d};
      other = w - d_ext;
      r     = d;
      if (en) begin
         if (w >= d_ext) begin
            if (other < d_ext) begin
               r = other[CW-1:0];
            end
         end else begin
            r = d - w[CW-1:0];
         end
      end
      return r;
   endfunction

   // point memories
   logic [CW-1:0] x_mem [pstd_pkg::MAX_POINTS];
   logic [CW-1:0] y_mem [pstd_pkg::MAX_POINTS];
   logic [CW-1:0] z_mem [pstd_pkg::MAX_POINTS];

   // latched request
   logic [pstd_pkg::REQ_W-1:0] op_ff;
   logic [IW-1:0]              ia_ff;
   logic [IW-1:0]              ib_ff;
   logic [CW-1:0]              cx_ff;
   logic [CW-1:0]              cy_ff;
   logic [CW-1:0]              cz_ff;

   logic [NW-1:0] count_ff;
   logic [NW-1:0] count_in;
   logic [IW-1:0] ptr_ff;

   // control registers
   logic          three_d_ff;
   logic          wrap_ff;
   logic [WW-1:0] width_x_ff;
   logic [WW-1:0] width_y_ff;
   logic [WW-1:0] width_z_ff;

   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   logic [CW-1:0] wx;
   logic [CW-1:0] wy;
   logic [CW-1:0] wz;
   logic          wz_en;
   logic [CW-1:0] rx_ff;
   logic [CW-1:0] ry_ff;
   logic [CW-1:0] rz_ff;

   logic [CW-1:0] pa_x_ff;
   logic [CW-1:0] pa_y_ff;
   logic [CW-1:0] pa_z_ff;
   logic [CW-1:0] d_x_ff;
   logic [CW-1:0] d_y_ff;
   logic [CW-1:0] d_z_ff;
   logic [CW-1:0] dw_x_ff;
   logic [CW-1:0] dw_y_ff;
   logic [CW-1:0] dw_z_ff;
   logic [CW-1:0] sq_in;
   logic [pstd_pkg::SQ_W-1:0]  prod_ff;
   logic [pstd_pkg::SUM_W-1:0] acc_ff;

   logic                        sqrt_done;
   logic [pstd_pkg::ROOT_W-1:0] root;

   pstd_pkg::status_type        res_status_ff;
   logic [pstd_pkg::ROOT_W-1:0] res_dist_ff;
   logic [CW-1:0]               res_x_ff;
   logic [CW-1:0]               res_y_ff;
   logic [CW-1:0]               res_z_ff;

   pstd_pkg::status_type        out_status_ff;
   logic [NW-1:0]               out_count_ff;
   logic [pstd_pkg::ROOT_W-1:0] out_dist_ff;
   logic [CW-1:0]               out_x_ff;
   logic [CW-1:0]               out_y_ff;
   logic [CW-1:0]               out_z_ff;

   // ---- status to the controller
   assign sts.op         = op_ff;
   assign sts.full       = (count_ff == NW'(pstd_pkg::MAX_POINTS));
   assign sts.empty      = (count_ff == '0);
   assign sts.a_ok       = (NW'(ia_ff) < count_ff);
   assign sts.b_ok       = (NW'(ib_ff) < count_ff);
   assign sts.same       = (ia_ff == ib_ff);
   assign sts.shift_last = ((NW'(ptr_ff) + NW'(1)) == count_ff);
   assign sts.sqrt_done  = sqrt_done;

   // ---- request latch
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff <= req_type;
         ia_ff <= req_index_a;
         ib_ff <= req_index_b;
         cx_ff <= req_coord_x;
         cy_ff <= req_coord_y;
         cz_ff <= req_coord_z;
      end
   end

   // ---- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         three_d_ff <= 1'b0;
         wrap_ff    <= 1'b0;
         width_x_ff <= pstd_pkg::WIDTH_RESET;
         width_y_ff <= pstd_pkg::WIDTH_RESET;
         width_z_ff <= pstd_pkg::WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            pstd_pkg::CSR_THREE_D: three_d_ff <= csr_wdata[0];
            pstd_pkg::CSR_WRAP:    wrap_ff    <= csr_wdata[0];
            pstd_pkg::CSR_WIDTH_X: width_x_ff <= csr_wdata;
            pstd_pkg::CSR_WIDTH_Y: width_y_ff <= csr_wdata;
            pstd_pkg::CSR_WIDTH_Z: width_z_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ---- point count and erase pointer
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + NW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ptr_load) begin
         ptr_ff <= ia_ff;
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + IW'(1);
      end
   end

   // ---- memory ports
   always_comb begin
      unique case (cmd.rd_sel)
         pstd_pkg::RD_A:    rd_addr = ia_ff;
         pstd_pkg::RD_B:    rd_addr = ib_ff;
         pstd_pkg::RD_NEXT: rd_addr = ptr_ff + IW'(1);
         default:           rd_addr = ia_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         pstd_pkg::WR_APPEND: begin
            wr_addr = count_ff[IW-1:0];
            wx      = cx_ff;
            wy      = cy_ff;
            wz      = three_d_ff ? cz_ff : '0;
            wz_en   = 1'b1;
         end
         pstd_pkg::WR_MOVE: begin
            wr_addr = ia_ff;
            wx      = cx_ff;
            wy      = cy_ff;
            wz      = cz_ff;
            wz_en   = three_d_ff;
         end
         pstd_pkg::WR_SHIFT: begin
            wr_addr = ptr_ff;
            wx      = rx_ff;
            wy      = ry_ff;
            wz      = rz_ff;
            wz_en   = 1'b1;
         end
         default: begin
            wr_addr = ptr_ff;
            wx      = rx_ff;
            wy      = ry_ff;
            wz      = rz_ff;
            wz_en   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         x_mem[wr_addr] <= wx;
         y_mem[wr_addr] <= wy;
         if (wz_en) begin
            z_mem[wr_addr] <= wz;
         end
      end
      rx_ff <= x_mem[rd_addr];
      ry_ff <= y_mem[rd_addr];
      rz_ff <= z_mem[rd_addr];
   end

   // ---- distance pipeline
   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         pa_x_ff <= rx_ff;
         pa_y_ff <= ry_ff;
         pa_z_ff <= rz_ff;
      end
      if (cmd.cap_diff) begin
         d_x_ff <= abs_diff(pa_x_ff, rx_ff);
         d_y_ff <= abs_diff(pa_y_ff, ry_ff);
         d_z_ff <= three_d_ff ? abs_diff(pa_z_ff, rz_ff) : '0;
      end
      if (cmd.cap_wrap) begin
         dw_x_ff <= fold(d_x_ff, width_x_ff, wrap_ff);
         dw_y_ff <= fold(d_y_ff, width_y_ff, wrap_ff);
         dw_z_ff <= three_d_ff ? fold(d_z_ff, width_z_ff, wrap_ff) : '0;
      end
   end

   always_comb begin
      unique case (cmd.sq_sel)
         pstd_pkg::AX_X: sq_in = dw_x_ff;
         pstd_pkg::AX_Y: sq_in = dw_y_ff;
         pstd_pkg::AX_Z: sq_in = dw_z_ff;
         default:        sq_in = dw_x_ff;
      endcase
   end

   // one shared squarer, product registered before the accumulate
   always_ff @(posedge clock) begin
      prod_ff <= sq_in * sq_in;
      unique case (cmd.acc_op)
         pstd_pkg::ACC_CLEAR: acc_ff <= '0;
         pstd_pkg::ACC_ADD:   acc_ff <= acc_ff + pstd_pkg::SUM_W'(prod_ff);
         default: begin
         end
      endcase
   end

   pstd_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   // ---- result and output registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_status_ff <= pstd_pkg::ST_OK;
         res_dist_ff   <= '0;
         res_x_ff      <= '0;
         res_y_ff      <= '0;
         res_z_ff      <= '0;
      end else begin
         if (cmd.status_we) begin
            res_status_ff <= cmd.status_code;
         end
         if (cmd.take_root) begin
            res_dist_ff <= root;
         end
         if (cmd.take_read) begin
            res_x_ff <= rx_ff;
            res_y_ff <= ry_ff;
            res_z_ff <= three_d_ff ? rz_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_count_ff  <= count_ff;
         out_dist_ff   <= res_dist_ff;
         out_x_ff      <= res_x_ff;
         out_y_ff      <= res_y_ff;
         out_z_ff      <= res_z_ff;
      end
   end

   assign rsp_point_count = out_count_ff;
   assign rsp_distance    = out_dist_ff;
   assign rsp_read_x      = out_x_ff;
   assign rsp_read_y      = out_y_ff;
   assign rsp_read_z      = out_z_ff;
   assign rsp_status      = out_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NW'(pstd_pkg::MAX_POINTS))
      else $error("point count beyond table size");

   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> !sts.full)
      else $error("append into a full table");

   a_dec_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> !sts.empty)
      else $error("count decremented from zero");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_we && cmd.wr_sel == pstd_pkg::WR_SHIFT)
         |-> ((NW'(ptr_ff) + NW'(1)) < count_ff))
      else $error("erase shift beyond last point");

endmodule

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for point_store_toroidal_distance. Directed tests
// cover the empty and full table, every request type, 2D/3D and toroidal
// window settings at their extremes, then a long random run in several
// window settings. A local model of the point table predicts every result;
// results are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_POINTS = pstd_pkg::MAX_POINTS;
   localparam int COORD_BITS = pstd_pkg::COORD_BITS;
   localparam int IDX_W      = pstd_pkg::IDX_W;
   localparam int CNT_W      = pstd_pkg::CNT_W;
   localparam int WIDTH_W    = pstd_pkg::WIDTH_W;
   localparam int ROOT_W     = pstd_pkg::ROOT_W;
   localparam int REQ_W      = pstd_pkg::REQ_W;
   localparam int STATUS_W   = pstd_pkg::STATUS_W;
   localparam int CSR_IDX_W  = pstd_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = pstd_pkg::CSR_DATA_W;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = pstd_pkg::WIDTH_RESET;

   // request codes the block does not decode: they must be answered with
   // status ok and must leave the table untouched
   localparam logic [REQ_W-1:0] REQ_RESERVED_A = 3'd6;
   localparam logic [REQ_W-1:0] REQ_RESERVED_B = 3'd7;

   // run limit, well above the slowest legal run
   localparam longint TIMEOUT_NS = 64'd10_000_000;

   typedef struct packed {
      logic [REQ_W-1:0]      code;
      logic [IDX_W-1:0]      ia;
      logic [IDX_W-1:0]      ib;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
   } request_type;

   typedef struct packed {
      logic [CNT_W-1:0]      count;
      logic [ROOT_W-1:0]     distance;
      logic [COORD_BITS-1:0] rx;
      logic [COORD_BITS-1:0] ry;
      logic [COORD_BITS-1:0] rz;
      logic [STATUS_W-1:0]   status;
   } answer_type;

   logic                    clock;
   logic                    reset;

   logic                    req_valid;
   logic                    req_stall;
   logic [REQ_W-1:0]        req_type;
   logic [IDX_W-1:0]        req_index_a;
   logic [IDX_W-1:0]        req_index_b;
   logic [COORD_BITS-1:0]   req_coord_x;
   logic [COORD_BITS-1:0]   req_coord_y;
   logic [COORD_BITS-1:0]   req_coord_z;

   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [CNT_W-1:0]        rsp_point_count;
   logic [ROOT_W-1:0]       rsp_distance;
   logic [COORD_BITS-1:0]   rsp_read_x;
   logic [COORD_BITS-1:0]   rsp_read_y;
   logic [COORD_BITS-1:0]   rsp_read_z;
   logic [STATUS_W-1:0]     rsp_status;

   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // local copy of the point table and window setup
   logic [COORD_BITS-1:0]   pt_x [MAX_POINTS];
   logic [COORD_BITS-1:0]   pt_y [MAX_POINTS];
   logic [COORD_BITS-1:0]   pt_z [MAX_POINTS];
   int unsigned             pt_count;
   logic                    win_3d;
   logic                    win_wrap;
   logic [WIDTH_W-1:0]      win_wx;
   logic [WIDTH_W-1:0]      win_wy;
   logic [WIDTH_W-1:0]      win_wz;

   // answers still owed by the block, oldest first
   answer_type              answer_q [$];
   answer_type              answer_due;
   int                      mismatches;

   // idling controls shared by the stimulus and the result side
   bit                      req_idle_on;
   bit                      rsp_idle_on;
   int                      rsp_hold_cycles;

   point_store_toroidal_distance i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_index_a     (req_index_a),
      .req_index_b     (req_index_b),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_point_count (rsp_point_count),
      .rsp_distance    (rsp_distance),
      .rsp_read_x      (rsp_read_x),
      .rsp_read_y      (rsp_read_y),
      .rsp_read_z      (rsp_read_z),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // squared axis difference; with wrap on the difference folds back into
   // the window, and a difference wider than the window just loses one width
   function automatic logic [63:0] fold_sq(logic [COORD_BITS-1:0] p,
                                           logic [COORD_BITS-1:0] q,
                                           logic [WIDTH_W-1:0] w);
      logic [63:0] pp, qq, d, wd, other;
      pp = p;
      qq = q;
      wd = w;
      d  = (pp > qq) ? pp - qq : qq - pp;
      if (win_wrap) begin
         if (wd >= d) begin
            other = wd - d;
            if (other < d) d = other;
         end else begin
            d = d - wd;
         end
      end
      return d * d;
   endfunction

   // floor square root, one root bit per trial from the top down
   function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] v);
      logic [63:0] root, trial;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root[ROOT_W-1:0];
   endfunction

   // applies one accepted request to the local table, returns the answer
   function automatic answer_type apply_request(request_type r);
      answer_type  a;
      logic [63:0] acc;
      int unsigned k;
      a        = '0;
      a.status = pstd_pkg::ST_OK;
      case (r.code)
         pstd_pkg::OP_APPEND: begin
            if (pt_count >= MAX_POINTS) begin
               a.status = pstd_pkg::ST_FULL;
            end else begin
               pt_x[pt_count] = r.x;
               pt_y[pt_count] = r.y;
               pt_z[pt_count] = win_3d ? r.z : '0;
               pt_count++;
            end
         end
         pstd_pkg::OP_DROP: begin
            if (pt_count == 0) a.status = pstd_pkg::ST_BAD_INDEX;
            else pt_count--;
         end
         pstd_pkg::OP_MOVE: begin
            if (r.ia >= pt_count) begin
               a.status = pstd_pkg::ST_BAD_INDEX;
            end else begin
               pt_x[r.ia] = r.x;
               pt_y[r.ia] = r.y;
               if (win_3d) pt_z[r.ia] = r.z;
            end
         end
         pstd_pkg::OP_ERASE: begin
            if (r.ia >= pt_count) begin
               a.status = pstd_pkg::ST_BAD_INDEX;
            end else begin
               for (k = r.ia; k + 1 < pt_count; k++) begin
                  pt_x[k] = pt_x[k+1];
                  pt_y[k] = pt_y[k+1];
                  pt_z[k] = pt_z[k+1];
               end
               pt_count--;
            end
         end
         pstd_pkg::OP_DIST: begin
            if (r.ia >= pt_count || r.ib >= pt_count) begin
               a.status = pstd_pkg::ST_BAD_INDEX;
            end else if (r.ia != r.ib) begin
               acc = fold_sq(pt_x[r.ia], pt_x[r.ib], win_wx)
                   + fold_sq(pt_y[r.ia], pt_y[r.ib], win_wy)
                   + (win_3d ? fold_sq(pt_z[r.ia], pt_z[r.ib], win_wz) : 64'd0);
               a.distance = floor_root(acc);
            end
         end
         pstd_pkg::OP_READ: begin
            if (r.ia >= pt_count) begin
               a.status = pstd_pkg::ST_BAD_INDEX;
            end else begin
               a.rx = pt_x[r.ia];
               a.ry = pt_y[r.ia];
               a.rz = win_3d ? pt_z[r.ia] : '0;
            end
         end
         default: ;
      endcase
      a.count = CNT_W'(pt_count);
      return a;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: random stall per item, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int n;
      forever begin
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            n = rsp_idle_on ? $urandom_range(0, 9) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // every item taken from the block is matched against the oldest answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            $error("result with nothing outstanding: count %0d status %0d",
                   rsp_point_count, rsp_status);
            mismatches++;
         end else begin
            answer_due = answer_q.pop_front();
            check_field("point_count", answer_due.count, rsp_point_count);
            check_field("distance", answer_due.distance, rsp_distance);
            check_field("read_x", answer_due.rx, rsp_read_x);
            check_field("read_y", answer_due.ry, rsp_read_y);
            check_field("read_z", answer_due.rz, rsp_read_z);
            check_field("status", answer_due.status, rsp_status);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // valid is left high after the handshake; the next item or a pause
   // decides whether it drops, so it never toggles twice in one step
   task automatic send_request(request_type r);
      int         gap;
      answer_type due;
      gap = req_idle_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= r.code;
      req_index_a <= r.ia;
      req_index_b <= r.ib;
      req_coord_x <= r.x;
      req_coord_y <= r.y;
      req_coord_z <= r.z;
      do @(posedge clock); while (req_stall);
      due      = apply_request(r);
      answer_q = {answer_q, due};
   endtask

   task automatic issue(logic [REQ_W-1:0] code, logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib,
                        logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                        logic [COORD_BITS-1:0] z);
      request_type r;
      r = '{code: code, ia: ia, ib: ib, x: x, y: y, z: z};
      send_request(r);
   endtask

   // sender pause: nothing offered until every answer is in
   task automatic drain_results();
      if (req_valid) req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   // writes all five control registers back to back; block must be idle
   task automatic set_window(logic td, logic wr, logic [WIDTH_W-1:0] wx,
                             logic [WIDTH_W-1:0] wy, logic [WIDTH_W-1:0] wz);
      pstd_pkg::csr_type     order [5];
      logic [CSR_DATA_W-1:0] vals  [5];
      order = '{pstd_pkg::CSR_THREE_D, pstd_pkg::CSR_WRAP, pstd_pkg::CSR_WIDTH_X,
                pstd_pkg::CSR_WIDTH_Y, pstd_pkg::CSR_WIDTH_Z};
      vals  = '{CSR_DATA_W'(td), CSR_DATA_W'(wr), wx, wy, wz};
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (order[i])
            pstd_pkg::CSR_THREE_D: win_3d   = vals[i][0];
            pstd_pkg::CSR_WRAP:    win_wrap = vals[i][0];
            pstd_pkg::CSR_WIDTH_X: win_wx   = vals[i];
            pstd_pkg::CSR_WIDTH_Y: win_wy   = vals[i];
            pstd_pkg::CSR_WIDTH_Z: win_wz   = vals[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // coordinates: extremes, values inside the window, and full range
   function automatic logic [COORD_BITS-1:0] pick_coord(logic [WIDTH_W-1:0] w);
      int          roll;
      int unsigned top;
      roll = $urandom_range(0, 99);
      top  = (w > 17'd65535) ? 65535 : w;
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      if (roll < 55) return COORD_BITS'($urandom_range(0, top));
      return COORD_BITS'($urandom);
   endfunction

   // mostly live indexes; some one past the end, some anywhere
   function automatic logic [IDX_W-1:0] pick_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (pt_count == 0 || roll < 6) return IDX_W'($urandom_range(0, MAX_POINTS - 1));
      if (roll < 9 && pt_count < MAX_POINTS) return IDX_W'(pt_count);
      return IDX_W'($urandom_range(0, pt_count - 1));
   endfunction

   function automatic logic [WIDTH_W-1:0] pick_width();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return WIDTH_RESET;
      if (roll < 40) return WIDTH_W'(1);
      if (roll < 70) return WIDTH_W'($urandom_range(2, 512));
      return WIDTH_W'($urandom_range(1, 65536));
   endfunction

   // request mix leans towards growth on a small table and towards erase
   // and drop on a larger one, so the table hovers around forty points
   function automatic request_type random_request();
      request_type r;
      int          roll;
      bit          grow;
      r.ia = pick_index();
      r.ib = ($urandom_range(0, 9) == 0) ? r.ia : pick_index();
      r.x  = pick_coord(win_wx);
      r.y  = pick_coord(win_wy);
      r.z  = pick_coord(win_wz);
      roll = $urandom_range(0, 99);
      grow = (pt_count < 40);
      if (roll < 2)                     r.code = roll[0] ? REQ_RESERVED_A : REQ_RESERVED_B;
      else if (roll < (grow ? 32 : 12)) r.code = pstd_pkg::OP_APPEND;
      else if (roll < (grow ? 37 : 24)) r.code = pstd_pkg::OP_DROP;
      else if (roll < (grow ? 49 : 36)) r.code = pstd_pkg::OP_MOVE;
      else if (roll < (grow ? 57 : 56)) r.code = pstd_pkg::OP_ERASE;
      else if (roll < (grow ? 85 : 84)) r.code = pstd_pkg::OP_DIST;
      else                              r.code = pstd_pkg::OP_READ;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // reset setup: 2D, no wrap, full window. Everything on an empty table is
   // a bad index, reserved codes pass through, z is dropped in 2D
   task automatic test_empty_table();
      issue(pstd_pkg::OP_DROP,  10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_READ,  10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_MOVE,  10'd0, 10'd0, 16'd7, 16'd8, 16'd9);
      issue(pstd_pkg::OP_ERASE, 10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,  10'd0, 10'd0, '0, '0, '0);
      issue(REQ_RESERVED_A, 10'd1023, 10'd1023, '1, '1, '1);
      issue(REQ_RESERVED_B, 10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_APPEND, 10'd0, 10'd0, '0, '0, 16'd1234);
      issue(pstd_pkg::OP_APPEND, 10'd0, 10'd0, '1, '1, '1);
      issue(pstd_pkg::OP_READ,  10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_READ,  10'd1, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,  10'd0, 10'd1, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,  10'd1, 10'd1, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,  10'd0, 10'd2, '0, '0, '0);
      issue(pstd_pkg::OP_READ,  10'd1023, 10'd0, '0, '0, '0);
   endtask

   // 3D with and without wrap, the unit window, and a 2D move that must
   // leave the stored z alone
   task automatic test_window_modes();
      drain_results();
      set_window(1'b1, 1'b0, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
      issue(pstd_pkg::OP_READ,   10'd1, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_MOVE,   10'd1, 10'd0, '1, '1, '1);
      issue(pstd_pkg::OP_DIST,   10'd0, 10'd1, '0, '0, '0);
      issue(pstd_pkg::OP_APPEND, 10'd0, 10'd0, 16'd32768, 16'd1, '1);
      drain_results();
      set_window(1'b1, 1'b1, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
      issue(pstd_pkg::OP_DIST,   10'd0, 10'd1, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,   10'd2, 10'd0, '0, '0, '0);
      drain_results();
      set_window(1'b1, 1'b1, WIDTH_W'(1), WIDTH_W'(1), WIDTH_W'(1));
      issue(pstd_pkg::OP_DIST,   10'd0, 10'd1, '0, '0, '0);
      issue(pstd_pkg::OP_ERASE,  10'd0, 10'd0, '0, '0, '0);
      drain_results();
      set_window(1'b0, 1'b0, WIDTH_RESET, WIDTH_W'(300), WIDTH_W'(1));
      issue(pstd_pkg::OP_MOVE,   10'd0, 10'd0, 16'd5, 16'd6, 16'd777);
      drain_results();
      set_window(1'b1, 1'b0, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
      issue(pstd_pkg::OP_READ,   10'd0, 10'd0, '0, '0, '0);
   endtask

   // fill to the limit, hit it, erase across the whole table, then drain
   // back to a handful of points for the random run
   task automatic test_full_table();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (pt_count < MAX_POINTS)
         issue(pstd_pkg::OP_APPEND, pick_index(), pick_index(),
               COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      issue(pstd_pkg::OP_APPEND, 10'd0, 10'd0, '1, '1, '1);
      issue(pstd_pkg::OP_READ,   10'd1023, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,   10'd0, 10'd1023, '0, '0, '0);
      issue(pstd_pkg::OP_ERASE,  10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_READ,   10'd0, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_READ,   10'd1022, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_READ,   10'd1023, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_DIST,   10'd1022, 10'd5, '0, '0, '0);
      issue(pstd_pkg::OP_ERASE,  10'd1022, 10'd0, '0, '0, '0);
      issue(pstd_pkg::OP_ERASE,  10'd511, 10'd0, '0, '0, '0);
      req_idle_on = 1'b0;
      while (pt_count > 8) issue(pstd_pkg::OP_DROP, pick_index(), pick_index(), '0, '0, '0);
      req_idle_on = 1'b1;
   endtask

   // result side holds off for a long stretch while items keep coming:
   // the block fills up and must stall its input; then wait for all answers
   task automatic test_backpressure();
      rsp_hold_cycles = 300;
      req_idle_on     = 1'b0;
      repeat (16) send_request(random_request());
      req_idle_on     = 1'b1;
      drain_results();
   endtask

   // eight phases, each with its own window setup; request and result idling are turned off in some phases
   task automatic test_random_traffic();
      for (int ph = 0; ph < 8; ph++) begin
         drain_results();
         case (ph)
            0: set_window(1'b0, 1'b0, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
            1: set_window(1'b1, 1'b1, WIDTH_RESET, WIDTH_RESET, WIDTH_RESET);
            2: set_window(1'b1, 1'b1, WIDTH_W'(1), WIDTH_W'(1), WIDTH_W'(1));
            3: set_window(1'b0, 1'b1, pick_width(), pick_width(), pick_width());
            default: set_window(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                pick_width(), pick_width(), pick_width());
         endcase
         req_idle_on = (ph != 4 && ph != 6);
         rsp_idle_on = (ph != 5 && ph != 6);
         repeat (106) send_request(random_request());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_type    <= pstd_pkg::OP_APPEND;
      req_index_a <= '0;
      req_index_b <= '0;
      req_coord_x <= '0;
      req_coord_y <= '0;
      req_coord_z <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= pstd_pkg::CSR_THREE_D;
      csr_wdata   <= '0;
      mismatches      = 0;
      rsp_hold_cycles = 0;
      req_idle_on     = 1'b1;
      rsp_idle_on     = 1'b1;
      pt_count        = 0;
      win_3d          = 1'b0;
      win_wrap        = 1'b0;
      win_wx          = WIDTH_RESET;
      win_wy          = WIDTH_RESET;
      win_wz          = WIDTH_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_window_modes();
      test_full_table();
      test_backpressure();
      test_random_traffic();

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
